FILE: rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg: buddy page allocator shared types and codes
// Beat layouts for the request and response channels, status and action codes.
// ---------------------------------------------------------------------------
package bpa_pkg;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_BLOCK  = 2'd1;
	localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

	typedef struct packed {
		logic        action;
		logic [19:0] request_bytes;
		logic [9:0]  page_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] block_page;
		logic [2:0] block_order;
	} rsp_t;

endpackage

FILE: rtl/buddy_page_allocator.sv
// ---------------------------------------------------------------------------
// buddy_page_allocator: buddy allocator over a page array
// Per-order LIFO free lists kept as doubly linked lists in page-indexed
// memories; allocate splits down, free merges up with same-order buddies.
// ---------------------------------------------------------------------------
// sequence: alloc pops the head of the first fitting list, splits and pushes
//   a buddy per level down to the wanted order, marks the page used; free
//   merges with each free same-order buddy up to max order, then pushes the
//   block; errors skip to the response register, which ends every request
// throughput: one request at a time, set by the read-modify-write walk over
//   the page memories; reset: after arst_n rises a clearing pass over all
//   pages builds the initial max-order list; requests are stalled till it ends
module buddy_page_allocator #(
	parameter int NUM_PAGES  = 1024,
	parameter int MAX_ORDER  = 6,
	parameter int PAGE_SHIFT = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bpa_pkg::rsp_t rsp
);

	localparam int AW   = $clog2(NUM_PAGES);
	localparam int LW   = $clog2(NUM_PAGES + 1);
	localparam int OW   = $clog2(MAX_ORDER + 1);
	localparam int SPAN = 1 << MAX_ORDER;
	localparam int NBLK = NUM_PAGES / SPAN;
	localparam int LAST = (NBLK > 0) ? (NBLK - 1) * SPAN : NUM_PAGES;
	localparam logic [LW-1:0] NONE = LW'(NUM_PAGES);
	localparam logic [OW-1:0] KMAX = OW'(MAX_ORDER);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_AFIND = 4'd2;
	localparam logic [3:0] S_ARD   = 4'd3;
	localparam logic [3:0] S_APOP  = 4'd4;
	localparam logic [3:0] S_SPLIT = 4'd5;
	localparam logic [3:0] S_PUSH2 = 4'd6;
	localparam logic [3:0] S_AFIN  = 4'd7;
	localparam logic [3:0] S_FRD   = 4'd8;
	localparam logic [3:0] S_FCHK  = 4'd9;
	localparam logic [3:0] S_BRD   = 4'd10;
	localparam logic [3:0] S_BCHK  = 4'd11;
	localparam logic [3:0] S_PUSH  = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	// page memories
	logic [OW-1:0] ord_mem  [NUM_PAGES];
	logic          free_mem [NUM_PAGES];
	logic [LW-1:0] next_mem [NUM_PAGES];
	logic [LW-1:0] prev_mem [NUM_PAGES];

	logic [OW-1:0] rd_ord_q;
	logic          rd_free_q;
	logic [LW-1:0] rd_next_q, rd_prev_q;

	logic [LW-1:0] head_q [MAX_ORDER+1];

	logic [3:0]    state_q;
	logic [AW-1:0] init_q;
	logic          op_q;
	logic [AW-1:0] p_q, b_q, pb_q;
	logic [OW-1:0] k_q, want_q;
	logic [LW-1:0] n_q;
	bpa_pkg::rsp_t res_q, rsp_q;
	logic          rsp_valid_q;

	logic [AW-1:0] ra;
	logic          ow_en, fw_en, nw_en, pw_en;
	logic [AW-1:0] ow_a, fw_a, nw_a, pw_a;
	logic [OW-1:0] ow_d;
	logic          fw_d;
	logic [LW-1:0] nw_d, pw_d;

	logic          hw_en;
	logic [OW-1:0] hw_idx;
	logic [LW-1:0] hw_val;

	logic [OW-1:0] want_c;
	logic          fits_c;
	logic [OW-1:0] fk_c;
	logic          found_c;
	logic [OW-1:0] kdn;
	logic [AW-1:0] bsplit, bbud;
	logic [OW-1:0] kfree;
	logic          load_rsp;
	int            iv;
	logic          ihead;

	assign kdn    = k_q - OW'(1);
	assign bsplit = p_q ^ (AW'(1) << kdn);
	assign bbud   = p_q ^ (AW'(1) << k_q);
	assign kfree  = (rd_ord_q > KMAX) ? KMAX : rd_ord_q;
	assign iv     = int'(init_q);
	assign ihead  = ((iv & (SPAN - 1)) == 0) && (iv + SPAN <= NUM_PAGES);

	// least order that holds the request
	always_comb begin
		want_c = '0;
		fits_c = 1'b0;
		for (int k = MAX_ORDER; k >= 0; k--) begin
			if ({44'd0, req.request_bytes} <= (64'd1 << (PAGE_SHIFT + k))) begin
				want_c = OW'(k);
				fits_c = 1'b1;
			end
		end
	end

	// first non-empty list at or above the wanted order
	always_comb begin
		fk_c    = '0;
		found_c = 1'b0;
		for (int k = MAX_ORDER; k >= 0; k--) begin
			if (OW'(k) >= want_q && head_q[k] != NONE) begin
				fk_c    = OW'(k);
				found_c = 1'b1;
			end
		end
	end

	assign ra = (state_q == S_BRD) ? bbud : p_q;

	always_comb begin
		ow_en = 1'b0; ow_a = p_q; ow_d = k_q;
		fw_en = 1'b0; fw_a = p_q; fw_d = 1'b1;
		nw_en = 1'b0; nw_a = p_q; nw_d = NONE;
		pw_en = 1'b0; pw_a = p_q; pw_d = NONE;
		hw_en = 1'b0; hw_idx = k_q; hw_val = NONE;
		case (state_q)
			S_INIT: begin
				ow_en = 1'b1; ow_a = init_q; ow_d = ihead ? KMAX : '0;
				fw_en = 1'b1; fw_a = init_q; fw_d = 1'b1;
				nw_en = 1'b1; nw_a = init_q;
				nw_d = (ihead && iv >= SPAN) ? LW'(iv - SPAN) : NONE;
				pw_en = 1'b1; pw_a = init_q;
				pw_d = (ihead && iv + 2 * SPAN <= NUM_PAGES) ? LW'(iv + SPAN) : NONE;
			end
			S_APOP: begin
				hw_en = 1'b1; hw_val = rd_next_q;
				if (rd_next_q != NONE) begin
					pw_en = 1'b1; pw_a = AW'(rd_next_q); pw_d = NONE;
				end
			end
			S_SPLIT: begin
				ow_en = 1'b1; ow_a = bsplit; ow_d = kdn;
				fw_en = 1'b1; fw_a = bsplit; fw_d = 1'b1;
				nw_en = 1'b1; nw_a = bsplit; nw_d = head_q[kdn];
				pw_en = 1'b1; pw_a = bsplit; pw_d = NONE;
				hw_en = 1'b1; hw_idx = kdn; hw_val = LW'(bsplit);
			end
			S_PUSH: begin
				ow_en = 1'b1;
				fw_en = 1'b1;
				nw_en = 1'b1; nw_d = head_q[k_q];
				pw_en = 1'b1;
				hw_en = 1'b1; hw_val = LW'(p_q);
			end
			S_PUSH2: begin
				if (n_q != NONE) begin
					pw_en = 1'b1; pw_a = AW'(n_q); pw_d = LW'(pb_q);
				end
			end
			S_AFIN: begin
				ow_en = 1'b1; ow_d = want_q;
				fw_en = 1'b1; fw_d = 1'b0;
			end
			S_FCHK: begin
				if (!rd_free_q) begin
					fw_en = 1'b1;
				end
			end
			S_BCHK: begin
				// unlink the buddy from its list
				if (rd_free_q && rd_ord_q == k_q) begin
					if (rd_prev_q != NONE) begin
						nw_en = 1'b1; nw_a = AW'(rd_prev_q); nw_d = rd_next_q;
					end else if (head_q[k_q] == LW'(b_q)) begin
						hw_en = 1'b1; hw_val = rd_next_q;
					end
					if (rd_next_q != NONE) begin
						pw_en = 1'b1; pw_a = AW'(rd_next_q); pw_d = rd_prev_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ow_en) ord_mem[ow_a] <= ow_d;
		if (fw_en) free_mem[fw_a] <= fw_d;
		if (nw_en) next_mem[nw_a] <= nw_d;
		if (pw_en) prev_mem[pw_a] <= pw_d;
		rd_ord_q  <= ord_mem[ra];
		rd_free_q <= free_mem[ra];
		rd_next_q <= next_mem[ra];
		rd_prev_q <= prev_mem[ra];
	end

	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			rsp_valid_q <= 1'b0;
			for (int k = 0; k <= MAX_ORDER; k++) begin
				head_q[k] <= (k == MAX_ORDER) ? LW'(LAST) : NONE;
			end
		end else begin
			if (hw_en) head_q[hw_idx] <= hw_val;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(NUM_PAGES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q   <= req.action;
						want_q <= want_c;
						p_q    <= AW'(req.page_index);
						if (req.action == bpa_pkg::ACT_FREE) begin
							if (int'(req.page_index) >= NUM_PAGES) begin
								res_q   <= '{bpa_pkg::STATUS_TOO_LARGE, req.page_index, 3'd0};
								state_q <= S_DONE;
							end else begin
								state_q <= S_FRD;
							end
						end else if (!fits_c) begin
							res_q   <= '{bpa_pkg::STATUS_TOO_LARGE, 10'd0, 3'd0};
							state_q <= S_DONE;
						end else begin
							state_q <= S_AFIND;
						end
					end
				end
				S_AFIND: begin
					if (found_c) begin
						p_q     <= AW'(head_q[fk_c]);
						k_q     <= fk_c;
						state_q <= S_ARD;
					end else begin
						res_q   <= '{bpa_pkg::STATUS_NO_BLOCK, 10'd0, 3'(want_q)};
						state_q <= S_DONE;
					end
				end
				S_ARD: state_q <= S_APOP;
				S_APOP: state_q <= (k_q > want_q) ? S_SPLIT : S_AFIN;
				S_SPLIT: begin
					n_q     <= head_q[kdn];
					pb_q    <= bsplit;
					k_q     <= kdn;
					state_q <= S_PUSH2;
				end
				S_PUSH: begin
					n_q     <= head_q[k_q];
					pb_q    <= p_q;
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (op_q == bpa_pkg::ACT_FREE) begin
						res_q   <= '{bpa_pkg::STATUS_OK, 10'(p_q), 3'(k_q)};
						state_q <= S_DONE;
					end else begin
						state_q <= (k_q > want_q) ? S_SPLIT : S_AFIN;
					end
				end
				S_AFIN: begin
					res_q   <= '{bpa_pkg::STATUS_OK, 10'(p_q), 3'(want_q)};
					state_q <= S_DONE;
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (rd_free_q) begin
						res_q   <= '{bpa_pkg::STATUS_NO_BLOCK, 10'(p_q), 3'd0};
						state_q <= S_DONE;
					end else begin
						k_q     <= kfree;
						state_q <= S_BRD;
					end
				end
				S_BRD: begin
					b_q     <= bbud;
					state_q <= (k_q == KMAX) ? S_PUSH : S_BCHK;
				end
				S_BCHK: begin
					if (rd_free_q && rd_ord_q == k_q) begin
						p_q     <= p_q & ~(AW'(1) << k_q);
						k_q     <= k_q + OW'(1);
						state_q <= S_BRD;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_DONE: begin
					if (load_rsp) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) rsp_q <= res_q;
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_init_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> req_stall)
		else $error("request taken during clearing pass");
	a_split_above: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |-> (k_q > want_q))
		else $error("split below wanted order");
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BRD || state_q == S_PUSH) |-> (k_q <= KMAX))
		else $error("order beyond max");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !rsp_valid_q) |=> rsp_valid_q)
		else $error("response not loaded");

endmodule
